// ===== src/monochrome_page_framebuffer_draw_defines.svh =====
// Assertion macros for the page framebuffer draw block.
// Used by the top level; needs nothing else.
`ifndef MONOCHROME_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH
`define MONOCHROME_PAGE_FRAMEBUFFER_DRAW_DEFINES_SVH

// same-cycle implication, off during reset
`define MPFD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define MPFD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset too
`define MPFD_ASSERT_NXT_ALL(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mpfd_pkg.sv =====
// Shared types and constants of the page framebuffer draw block.
// Used by every module of the block; depends on nothing.
`default_nettype none

package mpfd_pkg;

  localparam int MAX_WIDTH_DEF = 128;
  localparam int MAX_PAGES_DEF = 8;

  localparam int ACTION_W     = 3;
  localparam int FIELD_W      = 16;
  localparam int IDX_W        = 10;
  localparam int DATA_W       = 8;
  localparam int BIT_IDX_W    = 3;
  localparam int CW           = 19;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 8;
  localparam int WIDTH_REG_W  = 8;
  localparam int HEIGHT_REG_W = 7;
  localparam int DIV_STEPS    = FIELD_W;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(128);
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(64);

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = CFG_IDX_W'(1);

  typedef enum logic [ACTION_W-1:0] {
    ACT_SET_PIXEL   = 3'd0,
    ACT_CLEAR_PIXEL = 3'd1,
    ACT_LINE        = 3'd2,
    ACT_FILL_RECT   = 3'd3,
    ACT_OUTLINE     = 3'd4,
    ACT_CLEAR_ALL   = 3'd5,
    ACT_READ_BYTE   = 3'd6,
    ACT_NOP         = 3'd7
  } action_t;

  typedef enum logic [2:0] {
    SEG_PIXEL,
    SEG_FILL,
    SEG_TOP,
    SEG_BOTTOM,
    SEG_LEFT,
    SEG_RIGHT,
    SEG_VERT
  } seg_t;

  typedef struct packed {
    logic accept;
    logic line_prep;
    logic seg_load;
    seg_t seg;
    logic walk_load;
    logic walk_step;
    logic plot_issue;
    logic plot_src_dda;
    logic plot_clear;
    logic plot_write;
    logic div_start;
    logic dda_load;
    logic dda_step;
    logic sweep_load;
    logic sweep_all;
    logic sweep_step;
    logic read_issue;
    logic read_cap;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic is_vert;
    logic walk_empty;
    logic walk_last;
    logic div_done;
    logic dda_ok;
    logic dda_last;
    logic sweep_last;
    logic used_zero;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/mpfd_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on mpfd_pkg for the operand width.
`default_nettype none

module mpfd_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mpfd_pkg::FIELD_W-1:0] num,
  input  logic [mpfd_pkg::FIELD_W-1:0] den,
  output logic                         done,
  output logic [mpfd_pkg::FIELD_W-1:0] quo,
  output logic [mpfd_pkg::FIELD_W-1:0] rem
);
  import mpfd_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [FIELD_W:0]   acc;
  logic [FIELD_W-1:0] shreg;
  logic [FIELD_W-1:0] dv;
  logic [FIELD_W:0]   acc_sh;
  logic               fits;

  assign acc_sh = {acc[FIELD_W-1:0], shreg[FIELD_W-1]};
  assign fits   = acc_sh >= {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= '0;
      shreg <= num;
      dv    <= den;
    end else if (busy) begin
      acc   <= fits ? (acc_sh - {1'b0, dv}) : acc_sh;
      shreg <= {shreg[FIELD_W-2:0], fits};
    end
  end

  assign quo = shreg;
  assign rem = acc[FIELD_W-1:0];

endmodule

`default_nettype wire

// ===== src/mpfd_ctrl.sv =====
// Command sequencer of the page framebuffer draw block.
// Depends on mpfd_pkg for the action codes and the command and status types.
`default_nettype none

module mpfd_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mpfd_pkg::ACTION_W-1:0] action,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mpfd_pkg::cmd_t                cmd,
  input  mpfd_pkg::sts_t                sts
);
  import mpfd_pkg::*;

  typedef enum logic [3:0] {
    S_RST,
    S_CLR,
    S_IDLE,
    S_DECODE,
    S_SEG_A,
    S_SEG_B,
    S_WALK,
    S_PLOT_WR,
    S_SEG_END,
    S_DIV,
    S_DIVW,
    S_DDA_INIT,
    S_DDA,
    S_SWEEP,
    S_READ_CAP,
    S_DONE
  } state_t;

  localparam logic [1:0] LAST_SEG = 2'(3);

  state_t     state, state_next;
  state_t     ret, ret_next;
  action_t    act, act_next;
  logic [1:0] seg_k, seg_k_next;
  logic       out_valid_next;
  seg_t       seg_code;

  always_comb begin
    case (act)
      ACT_FILL_RECT: seg_code = SEG_FILL;
      ACT_LINE:      seg_code = SEG_VERT;
      ACT_OUTLINE: begin
        case (seg_k)
          2'd0:    seg_code = SEG_TOP;
          2'd1:    seg_code = SEG_BOTTOM;
          2'd2:    seg_code = SEG_LEFT;
          default: seg_code = SEG_RIGHT;
        endcase
      end
      default:       seg_code = SEG_PIXEL;
    endcase
  end

  always_comb begin
    state_next     = state;
    ret_next       = ret;
    act_next       = act;
    seg_k_next     = seg_k;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.seg        = seg_code;
    cmd.plot_clear = (act == ACT_CLEAR_PIXEL);
    case (state)
      S_RST: begin
        cmd.sweep_load = 1'b1;
        cmd.sweep_all  = 1'b1;
        state_next     = S_CLR;
      end
      S_CLR: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          act_next   = action_t'(action);
          seg_k_next = '0;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        case (act)
          ACT_SET_PIXEL, ACT_CLEAR_PIXEL, ACT_FILL_RECT, ACT_OUTLINE: begin
            state_next = S_SEG_A;
          end
          ACT_LINE: begin
            if (sts.is_vert) begin
              state_next = S_SEG_A;
            end else begin
              cmd.line_prep = 1'b1;
              state_next    = S_DIV;
            end
          end
          ACT_CLEAR_ALL: begin
            cmd.sweep_load = 1'b1;
            state_next     = sts.used_zero ? S_DONE : S_SWEEP;
          end
          ACT_READ_BYTE: begin
            cmd.read_issue = 1'b1;
            state_next     = S_READ_CAP;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_SEG_A: begin
        cmd.seg_load = 1'b1;
        state_next   = S_SEG_B;
      end
      S_SEG_B: begin
        cmd.walk_load = 1'b1;
        state_next    = sts.walk_empty ? S_SEG_END : S_WALK;
      end
      S_WALK: begin
        cmd.plot_issue = 1'b1;
        cmd.walk_step  = 1'b1;
        ret_next       = sts.walk_last ? S_SEG_END : S_WALK;
        state_next     = S_PLOT_WR;
      end
      S_PLOT_WR: begin
        cmd.plot_write = 1'b1;
        state_next     = ret;
      end
      S_SEG_END: begin
        if (act == ACT_OUTLINE && seg_k != LAST_SEG) begin
          seg_k_next = seg_k + 2'(1);
          state_next = S_SEG_A;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1;
        state_next    = S_DIVW;
      end
      S_DIVW: begin
        if (sts.div_done) begin
          state_next = S_DDA_INIT;
        end
      end
      S_DDA_INIT: begin
        cmd.dda_load = 1'b1;
        state_next   = S_DDA;
      end
      S_DDA: begin
        cmd.dda_step     = 1'b1;
        cmd.plot_src_dda = 1'b1;
        if (sts.dda_ok) begin
          cmd.plot_issue = 1'b1;
          ret_next       = sts.dda_last ? S_DONE : S_DDA;
          state_next     = S_PLOT_WR;
        end else if (sts.dda_last) begin
          state_next = S_DONE;
        end
      end
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_next = S_DONE;
        end
      end
      S_READ_CAP: begin
        cmd.read_cap = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_RST;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_RST;
      ret       <= S_DONE;
      act       <= ACT_NOP;
      seg_k     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ret       <= ret_next;
      act       <= act_next;
      seg_k     <= seg_k_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule

`default_nettype wire

// ===== src/mpfd_datapath.sv =====
// Datapath of the page framebuffer draw block: registers, pixel walkers,
// line stepper, byte store and result register. Depends on mpfd_pkg, mpfd_div.
`default_nettype none

module mpfd_datapath #(
  parameter int MAX_WIDTH = mpfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PAGES = mpfd_pkg::MAX_PAGES_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  mpfd_pkg::cmd_t                        cmd,
  output mpfd_pkg::sts_t                        sts,
  input  logic                                  cfg_we,
  input  logic [mpfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [mpfd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic signed [mpfd_pkg::FIELD_W-1:0]   point_a_x,
  input  logic signed [mpfd_pkg::FIELD_W-1:0]   point_a_y,
  input  logic signed [mpfd_pkg::FIELD_W-1:0]   point_b_x,
  input  logic signed [mpfd_pkg::FIELD_W-1:0]   point_b_y,
  input  logic [mpfd_pkg::FIELD_W-1:0]          rect_width,
  input  logic [mpfd_pkg::FIELD_W-1:0]          rect_height,
  input  logic [mpfd_pkg::IDX_W-1:0]            byte_index,
  output logic [mpfd_pkg::DATA_W-1:0]           read_data
);
  import mpfd_pkg::*;

  localparam int STORE = MAX_WIDTH * MAX_PAGES;
  localparam int AW    = $clog2(STORE);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int PGW   = $clog2(MAX_PAGES + 1);
  localparam int YW    = PGW + BIT_IDX_W;
  localparam int UW    = XW + PGW;
  localparam int CMPW  = (UW > IDX_W) ? UW : IDX_W;
  localparam int WCW   = WIDTH_REG_W + 1;
  localparam int PCW   = HEIGHT_REG_W - BIT_IDX_W + 1;

  function automatic logic [CW-1:0] clamp(input logic signed [CW-1:0] v,
                                          input logic [CW-1:0] lim);
    logic [CW-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if ($unsigned(v) > lim) begin
      r = lim;
    end else begin
      r = $unsigned(v);
    end
    return r;
  endfunction

  // configuration
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [XW-1:0]           w_eff;
  logic [PGW-1:0]          p_eff;
  logic [YW-1:0]           h_eff;
  logic [UW-1:0]           used;
  logic [CW-1:0]           w_lim;
  logic [CW-1:0]           h_lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH_IN_USE:  width_reg  <= cfg_data[WIDTH_REG_W-1:0];
        REG_HEIGHT_IN_USE: height_reg <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_eff = ({1'b0, width_reg} < WCW'(MAX_WIDTH)) ? XW'(width_reg) : XW'(MAX_WIDTH);
    p_eff = ({1'b0, height_reg[HEIGHT_REG_W-1:BIT_IDX_W]} < PCW'(MAX_PAGES))
          ? PGW'(height_reg[HEIGHT_REG_W-1:BIT_IDX_W]) : PGW'(MAX_PAGES);
    h_eff = {p_eff, {BIT_IDX_W{1'b0}}};
    used  = UW'(w_eff) * UW'(p_eff);
    w_lim = CW'(w_eff);
    h_lim = CW'(h_eff);
  end

  // captured item
  logic signed [FIELD_W-1:0] f_ax, f_ay, f_bx, f_by;
  logic [FIELD_W-1:0]        f_rw, f_rh;
  logic [IDX_W-1:0]          f_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      f_ax  <= point_a_x;
      f_ay  <= point_a_y;
      f_bx  <= point_b_x;
      f_by  <= point_b_y;
      f_rw  <= rect_width;
      f_rh  <= rect_height;
      f_idx <= byte_index;
    end
  end

  // segment bounds, exclusive ends
  logic signed [CW-1:0] ax, ay, rw, rh, ymin, ymax, one;
  logic signed [CW-1:0] xs_c, xe_c, ys_c, ye_c;
  logic signed [CW-1:0] s_xs, s_xe, s_ys, s_ye;

  always_comb begin
    one  = CW'(1);
    ax   = CW'(f_ax);
    ay   = CW'(f_ay);
    rw   = $signed(CW'(f_rw));
    rh   = $signed(CW'(f_rh));
    ymin = (f_ay < f_by) ? CW'(f_ay) : CW'(f_by);
    ymax = (f_ay < f_by) ? CW'(f_by) : CW'(f_ay);
    xs_c = ax;
    xe_c = ax + one;
    ys_c = ay;
    ye_c = ay + one;
    case (cmd.seg)
      SEG_FILL: begin
        xe_c = ax + rw;
        ye_c = ay + rh;
      end
      SEG_TOP: begin
        xe_c = ax + rw + one;
      end
      SEG_BOTTOM: begin
        xe_c = ax + rw + one;
        ys_c = ay + rh;
        ye_c = ay + rh + one;
      end
      SEG_LEFT: begin
        ye_c = ay + rh + one;
      end
      SEG_RIGHT: begin
        xs_c = ax + rw;
        xe_c = ax + rw + one;
        ye_c = ay + rh + one;
      end
      SEG_VERT: begin
        ys_c = ymin;
        ye_c = ymax + one;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_load) begin
      s_xs <= xs_c;
      s_xe <= xe_c;
      s_ys <= ys_c;
      s_ye <= ye_c;
    end
  end

  // rectangle walker over clipped bounds
  logic [CW-1:0] x0c, xec, y0c, yec;
  logic [XW-1:0] wk_xe, cx;
  logic [YW-1:0] wk_y0, wk_ye, cy;
  logic          cy_wrap;

  always_comb begin
    x0c = clamp(s_xs, w_lim);
    xec = clamp(s_xe, w_lim);
    y0c = clamp(s_ys, h_lim);
    yec = clamp(s_ye, h_lim);
  end

  assign cy_wrap = (cy + YW'(1)) == wk_ye;

  always_ff @(posedge clk) begin
    if (cmd.walk_load) begin
      wk_xe <= xec[XW-1:0];
      wk_y0 <= y0c[YW-1:0];
      wk_ye <= yec[YW-1:0];
      cx    <= x0c[XW-1:0];
      cy    <= y0c[YW-1:0];
    end else if (cmd.walk_step) begin
      if (cy_wrap) begin
        cy <= wk_y0;
        cx <= cx + XW'(1);
      end else begin
        cy <= cy + YW'(1);
      end
    end
  end

  // line set-up and divider
  logic signed [FIELD_W-1:0] l_x1, l_y1, l_x2;
  logic [FIELD_W-1:0]        l_dx;
  logic signed [FIELD_W:0]   l_dy;
  logic signed [FIELD_W:0]   dx_c, ady;
  logic                      swap;
  logic                      div_done;
  logic [FIELD_W-1:0]        div_q, div_r;

  assign swap = f_ax > f_bx;
  assign dx_c = swap ? ((FIELD_W+1)'(f_ax) - (FIELD_W+1)'(f_bx))
                     : ((FIELD_W+1)'(f_bx) - (FIELD_W+1)'(f_ax));
  assign ady  = l_dy[FIELD_W] ? -l_dy : l_dy;

  always_ff @(posedge clk) begin
    if (cmd.line_prep) begin
      l_x1 <= swap ? f_bx : f_ax;
      l_y1 <= swap ? f_by : f_ay;
      l_x2 <= swap ? f_ax : f_bx;
      l_dx <= dx_c[FIELD_W-1:0];
      l_dy <= swap ? ((FIELD_W+1)'(f_ay) - (FIELD_W+1)'(f_by))
                   : ((FIELD_W+1)'(f_by) - (FIELD_W+1)'(f_ay));
    end
  end

  mpfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (ady[FIELD_W-1:0]),
    .den   (l_dx),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // line stepper: floor quotient and remainder of the running row
  logic signed [CW-1:0] d_i, d_q, d_qd, qz, t_row;
  logic [FIELD_W-1:0]   d_r, d_rd;
  logic [FIELD_W:0]     r_sum;
  logic                 r_carry;
  logic                 dda_ok, dda_last;

  assign qz      = $signed(CW'(div_q));
  assign r_sum   = {1'b0, d_r} + {1'b0, d_rd};
  assign r_carry = r_sum >= {1'b0, l_dx};
  assign t_row   = (d_q < 0 && d_r != '0) ? (d_q + CW'(1)) : d_q;

  always_comb begin
    dda_ok   = !d_i[CW-1] && ($unsigned(d_i) < w_lim) &&
               !t_row[CW-1] && ($unsigned(t_row) < h_lim);
    dda_last = (d_i == CW'(l_x2)) || (!d_i[CW-1] && ($unsigned(d_i) >= w_lim));
  end

  always_ff @(posedge clk) begin
    if (cmd.dda_load) begin
      d_i <= CW'(l_x1);
      d_q <= CW'(l_y1);
      d_r <= '0;
      if (l_dy[FIELD_W] && div_r != '0) begin
        d_qd <= ~qz;
        d_rd <= l_dx - div_r;
      end else if (l_dy[FIELD_W]) begin
        d_qd <= -qz;
        d_rd <= '0;
      end else begin
        d_qd <= qz;
        d_rd <= div_r;
      end
    end else if (cmd.dda_step) begin
      d_i <= d_i + CW'(1);
      d_q <= d_q + d_qd + $signed(CW'(r_carry));
      d_r <= r_carry ? FIELD_W'(r_sum - {1'b0, l_dx}) : r_sum[FIELD_W-1:0];
    end
  end

  // pixel to byte address, mirrored
  logic [XW-1:0]        px, mx;
  logic [YW-1:0]        py, my;
  logic [UW-1:0]        addr_full;
  logic [AW-1:0]        p_addr_c, p_addr, rd_addr;
  logic [BIT_IDX_W-1:0] p_bit;
  logic                 p_clr;

  always_comb begin
    px        = cmd.plot_src_dda ? d_i[XW-1:0] : cx;
    py        = cmd.plot_src_dda ? t_row[YW-1:0] : cy;
    mx        = w_eff - XW'(1) - px;
    my        = h_eff - YW'(1) - py;
    addr_full = UW'(my[YW-1:BIT_IDX_W]) * UW'(w_eff) + UW'(mx);
    p_addr_c  = addr_full[AW-1:0];
    rd_addr   = cmd.read_issue ? AW'(f_idx) : p_addr_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.plot_issue) begin
      p_addr <= p_addr_c;
      p_bit  <= my[BIT_IDX_W-1:0];
      p_clr  <= cmd.plot_clear;
    end
  end

  // clearing sweep
  logic [UW-1:0] sw_cnt, sw_end;

  always_ff @(posedge clk) begin
    if (cmd.sweep_load) begin
      sw_cnt <= '0;
      sw_end <= cmd.sweep_all ? UW'(STORE) : used;
    end else if (cmd.sweep_step) begin
      sw_cnt <= sw_cnt + UW'(1);
    end
  end

  // byte store
  logic [DATA_W-1:0] mem [STORE];
  logic [DATA_W-1:0] rd_data, mask, wr_data;
  logic [AW-1:0]     wr_addr;
  logic              we;

  always_comb begin
    mask    = DATA_W'(1) << p_bit;
    we      = cmd.sweep_step || cmd.plot_write;
    wr_addr = cmd.sweep_step ? sw_cnt[AW-1:0] : p_addr;
    if (cmd.sweep_step) begin
      wr_data = '0;
    end else if (p_clr) begin
      wr_data = rd_data & ~mask;
    end else begin
      wr_data = rd_data | mask;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // result
  logic [DATA_W-1:0] res, out_data;
  logic              rd_ok;

  assign rd_ok = CMPW'(f_idx) < CMPW'(used);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res <= '0;
    end else if (cmd.read_cap) begin
      res <= rd_ok ? rd_data : '0;
    end
    if (cmd.out_load) begin
      out_data <= res;
    end
  end

  assign read_data = out_data;

  always_comb begin
    sts            = '0;
    sts.is_vert    = (f_ax == f_bx);
    sts.walk_empty = (x0c >= xec) || (y0c >= yec);
    sts.walk_last  = cy_wrap && ((cx + XW'(1)) == wk_xe);
    sts.div_done   = div_done;
    sts.dda_ok     = dda_ok;
    sts.dda_last   = dda_last;
    sts.sweep_last = (sw_cnt + UW'(1)) == sw_end;
    sts.used_zero  = (used == '0);
  end

endmodule

`default_nettype wire

// ===== src/monochrome_page_framebuffer_draw.sv =====
// Page-layout 1-bit framebuffer with drawing commands, top level.
// Uses mpfd_pkg, mpfd_ctrl, mpfd_datapath and the assertion macro header.
//
// Input channel: in_valid/in_stall with one command per item (action, two
// points, rectangle size, byte_index). Output channel: out_valid/out_stall
// with read_data, exactly one item per command, in command order.
// Configuration: cfg_valid/cfg_ready (always ready), cfg_index 0 sets the
// width in use, 1 the height in use; write only while no command is open.
// One command is in work at a time; a new command is taken while the
// previous result still waits in the output register.
// Work per command: a pixel set or clear walks a single pixel; clear-all
// zeroes only the bytes in use. Fill, outline and vertical line load each
// edge (outline has four) and spend a read and a write of the store per
// clipped pixel. Other lines run the 16 divider steps, then walk the
// columns and write each drawn pixel (read-modify-write of the store).
// The next item can be taken as soon as out_valid rises.
// Reset: the store is swept to zero, one byte per cycle, over all
// MAX_WIDTH*MAX_PAGES bytes (1024 by default); in_stall stays high until
// it ends. A stalled result holds; the block finishes its next command and
// waits with it until the output register frees.
`default_nettype none

`include "monochrome_page_framebuffer_draw_defines.svh"

module monochrome_page_framebuffer_draw #(
  parameter int MAX_WIDTH = mpfd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_PAGES = mpfd_pkg::MAX_PAGES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [mpfd_pkg::ACTION_W-1:0]       action,
  input  logic signed [mpfd_pkg::FIELD_W-1:0] point_a_x,
  input  logic signed [mpfd_pkg::FIELD_W-1:0] point_a_y,
  input  logic signed [mpfd_pkg::FIELD_W-1:0] point_b_x,
  input  logic signed [mpfd_pkg::FIELD_W-1:0] point_b_y,
  input  logic [mpfd_pkg::FIELD_W-1:0]        rect_width,
  input  logic [mpfd_pkg::FIELD_W-1:0]        rect_height,
  input  logic [mpfd_pkg::IDX_W-1:0]          byte_index,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [mpfd_pkg::DATA_W-1:0]         read_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mpfd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mpfd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import mpfd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  mpfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  mpfd_datapath #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .point_a_x   (point_a_x),
    .point_a_y   (point_a_y),
    .point_b_x   (point_b_x),
    .point_b_y   (point_b_y),
    .rect_width  (rect_width),
    .rect_height (rect_height),
    .byte_index  (byte_index),
    .read_data   (read_data)
  );

  `MPFD_ASSERT_NXT(a_one_item_open, clk, rst, in_valid && !in_stall, in_stall, "item taken while busy")
  `MPFD_ASSERT_NXT_ALL(a_reset_sweep_stalls, clk, rst, in_stall, "input open during clearing sweep")
  `MPFD_ASSERT_IMP(a_result_after_work, clk, rst, $rose(out_valid), $past(in_stall), "result without work")

endmodule

`default_nettype wire
